// ===== rtl/core/fzn_pkg.sv =====
// Shared types and constants for the feature z-score normaliser.
// Used by every module under rtl/core; has no dependencies of its own.
package fzn_pkg;

    localparam int MAX_FEATURES = 64;
    localparam int FEAT_AW      = $clog2(MAX_FEATURES);
    localparam int MAX_SAMPLES  = 65536;
    localparam int CNT_W        = 17;
    localparam int SUM_W        = 40;
    localparam int SQ_W         = 62;
    localparam int Q_W          = 24;
    localparam int FC_W         = 7;

    localparam logic signed [Q_W-1:0] Q_MAX = 24'sd8388607;
    localparam logic signed [Q_W-1:0] Q_MIN = -24'sd8388608;

    typedef enum logic [2:0] {
        KIND_ACC     = 3'd0,
        KIND_NORM    = 3'd1,
        KIND_LD_MEAN = 3'd2,
        KIND_LD_PREC = 3'd3,
        KIND_FINAL   = 3'd4
    } t_kind;

    typedef struct packed {
        logic [2:0]              kind;
        logic [5:0]              feature_index;
        logic signed [Q_W-1:0]   value;
        logic                    sample_end;
    } t_in_item;

    typedef struct packed {
        logic [5:0]              out_feature;
        logic signed [Q_W-1:0]   normalized;
        logic                    stats_ready;
    } t_out_item;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [SQ_W-1:0]         sq;
    } t_acc_entry;

    typedef struct packed {
        logic signed [Q_W-1:0]   mean;
        logic signed [Q_W-1:0]   prec;
    } t_stat_entry;

    typedef struct packed {
        logic               rd_en;
        logic [FEAT_AW-1:0] rd_addr;
        logic               wr_en;
        logic [FEAT_AW-1:0] wr_addr;
    } t_mem_ctl;

    typedef enum logic [2:0] {
        CTL_IDLE,
        CTL_EXEC,
        CTL_FIN_RD,
        CTL_FIN_GO,
        CTL_FIN_WAIT,
        CTL_FIN_END
    } t_ctl_state;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MEAN,
        ST_MUL_D,
        ST_MUL_A,
        ST_MUL_B,
        ST_DIFF,
        ST_DIV_V,
        ST_DIV_T,
        ST_SQRT,
        ST_DONE
    } t_fin_state;

endpackage

// ===== rtl/core/fzn_ram.sv =====
// Synchronous single-write, single-read RAM with per-entry valid bits.
// Entries read as zero until written; depends on fzn_pkg for depth and control type.
module fzn_ram #(
    parameter int WIDTH = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fzn_pkg::t_mem_ctl i_ctl,
    input  logic              i_clr,
    input  logic [WIDTH-1:0]  i_wr_data,
    output logic [WIDTH-1:0]  o_rd_data
);
    import fzn_pkg::*;

    logic [WIDTH-1:0]        mem [MAX_FEATURES];
    logic [MAX_FEATURES-1:0] r_valid;
    logic [WIDTH-1:0]        r_rd;
    logic                    r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            mem[i_ctl.wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd <= mem[i_ctl.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_clr) begin
                r_valid <= '0;
            end else if (i_ctl.wr_en) begin
                r_valid[i_ctl.wr_addr] <= 1'b1;
            end
            if (i_ctl.rd_en) begin
                r_rd_valid <= r_valid[i_ctl.rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd : '0;

endmodule

// ===== rtl/core/fzn_stats.sv =====
// Multi-cycle statistics unit: mean by restoring division, precision by
// shift-add products, two long divisions and a bitwise square root. Uses fzn_pkg.
module fzn_stats (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [fzn_pkg::SUM_W-1:0]  i_sum,
    input  logic [fzn_pkg::SQ_W-1:0]          i_sq,
    input  logic [fzn_pkg::CNT_W-1:0]         i_n,
    output logic                              o_done,
    output logic signed [fzn_pkg::Q_W-1:0]    o_mean,
    output logic signed [fzn_pkg::Q_W-1:0]    o_prec
);
    import fzn_pkg::*;

    t_fin_state r_state, n_state;

    logic [6:0]              r_cnt;
    logic                    r_neg;
    logic [SUM_W-1:0]        r_mag;
    logic [SQ_W-1:0]         r_sq;
    logic [CNT_W-1:0]        r_n;
    logic [79:0]             r_dvd;
    logic [63:0]             r_dvs;
    logic [64:0]             r_rem;
    logic [79:0]             r_quo;
    logic [79:0]             r_mcand;
    logic [39:0]             r_mplier;
    logic [79:0]             r_prod;
    logic [79:0]             r_a;
    logic [31:0]             r_d;
    logic [63:0]             r_x;
    logic [63:0]             r_res;
    logic [63:0]             r_bit;
    logic signed [Q_W-1:0]   r_mean;
    logic signed [Q_W-1:0]   r_prec;

    logic [SUM_W-1:0] in_mag;
    logic             last;
    logic [64:0]      div_sh;
    logic             div_ge;
    logic [64:0]      div_rem_n;
    logic [79:0]      div_quo_n;
    logic [79:0]      mul_prod_n;
    logic [63:0]      sq_trial;
    logic             sq_ge;
    logic [63:0]      sq_x_n;
    logic [63:0]      sq_res_n;
    logic [63:0]      v_n;
    logic             v_small;
    logic [39:0]      q40;
    logic signed [Q_W-1:0] mean_n;

    assign in_mag = i_sum[SUM_W-1] ? SUM_W'(-i_sum) : SUM_W'(i_sum);
    assign last   = (r_cnt == 7'd1);

    // One restoring division step, shared by the three division phases.
    assign div_sh    = {r_rem[63:0], r_dvd[79]};
    assign div_ge    = div_sh >= {1'b0, r_dvs};
    assign div_rem_n = div_ge ? (div_sh - {1'b0, r_dvs}) : div_sh;
    assign div_quo_n = {r_quo[78:0], div_ge};

    assign mul_prod_n = r_mplier[0] ? (r_prod + r_mcand) : r_prod;

    assign sq_trial = r_res + r_bit;
    assign sq_ge    = r_x >= sq_trial;
    assign sq_x_n   = sq_ge ? (r_x - sq_trial) : r_x;
    assign sq_res_n = sq_ge ? ((r_res >> 1) + r_bit) : (r_res >> 1);

    // The variance quotient saturates to 64 bits.
    assign v_n     = (|div_quo_n[79:64]) ? '1 : div_quo_n[63:0];
    assign v_small = (v_n <= 64'd1);

    assign q40 = div_quo_n[39:0];
    always_comb begin
        if (r_n == '0) begin
            mean_n = '0;
        end else if (r_neg) begin
            mean_n = (q40 >= 40'd8388608) ? Q_MIN : Q_W'(24'd0 - q40[23:0]);
        end else begin
            mean_n = (q40 >= 40'd8388607) ? Q_MAX : $signed(q40[23:0]);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_start) n_state = ST_MEAN;
            ST_MEAN:  if (last) n_state = (r_n < CNT_W'(2)) ? ST_DONE : ST_MUL_D;
            ST_MUL_D: if (last) n_state = ST_MUL_A;
            ST_MUL_A: if (last) n_state = ST_MUL_B;
            ST_MUL_B: if (last) n_state = ST_DIFF;
            ST_DIFF:  n_state = (r_a > r_prod) ? ST_DIV_V : ST_DONE;
            ST_DIV_V: if (last) n_state = v_small ? ST_DONE : ST_DIV_T;
            ST_DIV_T: if (last) n_state = ST_SQRT;
            ST_SQRT:  if (last) n_state = ST_DONE;
            ST_DONE:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    r_neg  <= i_sum[SUM_W-1];
                    r_mag  <= in_mag;
                    r_sq   <= i_sq;
                    r_n    <= i_n;
                    r_dvd  <= {in_mag + SUM_W'(i_n >> 1), 40'd0};
                    r_dvs  <= 64'(i_n);
                    r_rem  <= '0;
                    r_cnt  <= 7'd40;
                    r_prec <= Q_MAX;
                end
            end
            ST_MEAN: begin
                r_rem <= div_rem_n;
                r_quo <= div_quo_n;
                r_dvd <= r_dvd << 1;
                r_cnt <= r_cnt - 7'd1;
                if (last) begin
                    r_mean   <= mean_n;
                    r_mcand  <= 80'(r_n);
                    r_mplier <= 40'(r_n - CNT_W'(1));
                    r_prod   <= '0;
                    r_cnt    <= 7'd17;
                end
            end
            ST_MUL_D, ST_MUL_A, ST_MUL_B: begin
                r_prod   <= mul_prod_n;
                r_mcand  <= r_mcand << 1;
                r_mplier <= r_mplier >> 1;
                r_cnt    <= r_cnt - 7'd1;
                if (last && r_state == ST_MUL_D) begin
                    r_d      <= mul_prod_n[31:0];
                    r_mcand  <= 80'(r_sq);
                    r_mplier <= 40'(r_n);
                    r_prod   <= '0;
                    r_cnt    <= 7'd17;
                end
                if (last && r_state == ST_MUL_A) begin
                    r_a      <= mul_prod_n;
                    r_mcand  <= 80'(r_mag);
                    r_mplier <= r_mag;
                    r_prod   <= '0;
                    r_cnt    <= 7'd40;
                end
            end
            ST_DIFF: begin
                r_dvd <= r_a - r_prod;
                r_dvs <= 64'(r_d);
                r_rem <= '0;
                r_cnt <= 7'd80;
            end
            ST_DIV_V, ST_DIV_T: begin
                r_rem <= div_rem_n;
                r_quo <= div_quo_n;
                r_dvd <= r_dvd << 1;
                r_cnt <= r_cnt - 7'd1;
                if (last && r_state == ST_DIV_V) begin
                    // Next: floor(2^64 / V) as a 65-bit dividend.
                    r_dvd <= {1'b1, 79'd0};
                    r_dvs <= v_n;
                    r_rem <= '0;
                    r_cnt <= 7'd65;
                end
                if (last && r_state == ST_DIV_T) begin
                    r_x   <= div_quo_n[63:0];
                    r_res <= '0;
                    r_bit <= 64'h4000_0000_0000_0000;
                    r_cnt <= 7'd32;
                end
            end
            ST_SQRT: begin
                r_x   <= sq_x_n;
                r_res <= sq_res_n;
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt - 7'd1;
                if (last) begin
                    r_prec <= (sq_res_n > 64'(Q_MAX)) ? Q_MAX : $signed(sq_res_n[23:0]);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_done = (r_state == ST_DONE);
    assign o_mean = r_mean;
    assign o_prec = r_prec;

endmodule

// ===== rtl/core/feature_zscore_normalizer_core.sv =====
// For accumulate, load and normalise beats, busy is high for one cycle after
// acceptance, and a normalise result is strobed in the cycle after that.
// Finalise stays busy while it runs the statistics unit on each feature below the
// feature count, each done sooner with under two samples or a zero or tiny variance.
// The receiver cannot stall. Synchronous reset clears all control state and
// the RAM valid bits, so every store reads as zero after reset.
module feature_zscore_normalizer_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  fzn_pkg::t_in_item             i_item,
    input  logic                          i_cfg_we,
    input  logic [fzn_pkg::FC_W-1:0]      i_cfg_wdata,
    output logic                          o_strobe,
    output fzn_pkg::t_out_item            o_result
);
    import fzn_pkg::*;

    t_ctl_state r_state, n_state;

    t_in_item          r_item;
    logic [FC_W-1:0]   r_fc;
    logic [CNT_W-1:0]  r_count;
    logic              r_ready;
    logic [FC_W-1:0]   r_fidx;
    logic              r_strobe;
    t_out_item         r_result;

    logic              accept;
    logic [FC_W-1:0]   lim;
    t_mem_ctl          acc_ctl, stat_ctl;
    logic              acc_clr;
    t_acc_entry        acc_wr, acc_rd;
    t_stat_entry       stat_wr, stat_rd;
    logic              st_start, st_done;
    logic signed [Q_W-1:0] st_mean, st_prec;

    logic signed [SUM_W:0]   sum_ext;
    logic signed [47:0]      val_sqr;
    logic [SQ_W:0]           sq_ext;
    logic signed [Q_W:0]     diff;
    logic signed [49:0]      prod;
    logic signed [33:0]      scaled;
    logic signed [Q_W-1:0]   norm;

    assign busy   = (r_state != CTL_IDLE);
    assign accept = start && !busy;
    assign lim    = (r_fc > FC_W'(MAX_FEATURES)) ? FC_W'(MAX_FEATURES) : r_fc;

    // Accumulate with saturation.
    assign sum_ext = (SUM_W+1)'(acc_rd.sum) + (SUM_W+1)'(r_item.value);
    assign val_sqr = r_item.value * r_item.value;
    assign sq_ext  = (SQ_W+1)'(acc_rd.sq) + (SQ_W+1)'($unsigned(val_sqr));
    always_comb begin
        if (sum_ext > (SUM_W+1)'(41'sd549755813887)) begin
            acc_wr.sum = {1'b0, {(SUM_W-1){1'b1}}};
        end else if (sum_ext < -(SUM_W+1)'(41'sd549755813888)) begin
            acc_wr.sum = {1'b1, {(SUM_W-1){1'b0}}};
        end else begin
            acc_wr.sum = sum_ext[SUM_W-1:0];
        end
        acc_wr.sq = sq_ext[SQ_W] ? '1 : sq_ext[SQ_W-1:0];
    end

    // Normalise: round half up at bit 16, then saturate to Q7.16.
    assign diff   = (Q_W+1)'(r_item.value) - (Q_W+1)'(stat_rd.mean);
    assign prod   = 50'(diff * stat_rd.prec) + 50'sd32768;
    assign scaled = 34'(prod >>> 16);
    always_comb begin
        if (scaled > 34'(Q_MAX)) begin
            norm = Q_MAX;
        end else if (scaled < 34'(Q_MIN)) begin
            norm = Q_MIN;
        end else begin
            norm = scaled[Q_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            CTL_IDLE:     if (accept) n_state = CTL_EXEC;
            CTL_EXEC:     n_state = (r_item.kind == KIND_FINAL) ? CTL_FIN_RD : CTL_IDLE;
            CTL_FIN_RD:   n_state = (r_fidx < lim) ? CTL_FIN_GO : CTL_FIN_END;
            CTL_FIN_GO:   n_state = CTL_FIN_WAIT;
            CTL_FIN_WAIT: if (st_done) n_state = CTL_FIN_RD;
            CTL_FIN_END:  n_state = CTL_IDLE;
            default:      n_state = CTL_IDLE;
        endcase
    end

    always_comb begin
        acc_ctl  = '0;
        stat_ctl = '0;
        acc_clr  = 1'b0;
        st_start = 1'b0;
        stat_wr  = stat_rd;
        unique case (r_state)
            CTL_IDLE: begin
                acc_ctl.rd_en   = accept;
                acc_ctl.rd_addr = i_item.feature_index;
                stat_ctl.rd_en  = accept;
                stat_ctl.rd_addr = i_item.feature_index;
            end
            CTL_EXEC: begin
                acc_ctl.wr_en    = (r_item.kind == KIND_ACC);
                acc_ctl.wr_addr  = r_item.feature_index;
                stat_ctl.wr_en   = (r_item.kind == KIND_LD_MEAN) ||
                                   (r_item.kind == KIND_LD_PREC);
                stat_ctl.wr_addr = r_item.feature_index;
                if (r_item.kind == KIND_LD_MEAN) begin
                    stat_wr.mean = r_item.value;
                end else begin
                    stat_wr.prec = r_item.value;
                end
            end
            CTL_FIN_RD: begin
                acc_ctl.rd_en   = (r_fidx < lim);
                acc_ctl.rd_addr = r_fidx[FEAT_AW-1:0];
            end
            CTL_FIN_GO: begin
                st_start = 1'b1;
            end
            CTL_FIN_WAIT: begin
                stat_ctl.wr_en   = st_done;
                stat_ctl.wr_addr = r_fidx[FEAT_AW-1:0];
                stat_wr.mean     = st_mean;
                stat_wr.prec     = st_prec;
            end
            CTL_FIN_END: begin
                acc_clr = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= CTL_IDLE;
            r_fc     <= FC_W'(MAX_FEATURES);
            r_count  <= '0;
            r_ready  <= 1'b0;
            r_fidx   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == CTL_EXEC) && (r_item.kind == KIND_NORM);
            if (i_cfg_we) begin
                r_fc <= i_cfg_wdata;
            end
            if (r_state == CTL_EXEC) begin
                r_fidx <= '0;
                if (r_item.kind == KIND_ACC && r_item.sample_end &&
                    r_count < CNT_W'(MAX_SAMPLES)) begin
                    r_count <= r_count + CNT_W'(1);
                end
                if (r_item.kind == KIND_LD_MEAN || r_item.kind == KIND_LD_PREC) begin
                    r_ready <= 1'b1;
                end
            end
            if (r_state == CTL_FIN_WAIT && st_done) begin
                r_fidx <= r_fidx + FC_W'(1);
            end
            if (r_state == CTL_FIN_END) begin
                r_count <= '0;
                r_ready <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
        if (r_state == CTL_EXEC) begin
            r_result.out_feature <= r_item.feature_index;
            r_result.normalized  <= norm;
            r_result.stats_ready <= r_ready;
        end
    end

    fzn_ram #(.WIDTH($bits(t_acc_entry))) u_acc_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (acc_ctl),
        .i_clr     (acc_clr),
        .i_wr_data (acc_wr),
        .o_rd_data (acc_rd)
    );

    fzn_ram #(.WIDTH($bits(t_stat_entry))) u_stat_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (stat_ctl),
        .i_clr     (1'b0),
        .i_wr_data (stat_wr),
        .o_rd_data (stat_rd)
    );

    fzn_stats u_stats (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (st_start),
        .i_sum   (acc_rd.sum),
        .i_sq    (acc_rd.sq),
        .i_n     (r_count),
        .o_done  (st_done),
        .o_mean  (st_mean),
        .o_prec  (st_prec)
    );

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    a_strobe_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy)) else $error("result beat without a preceding execute cycle");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe) else $error("result beat lasted more than one cycle");

    a_stats_done_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_done |-> (r_state == CTL_FIN_WAIT)) else $error("statistics unit finished outside the walk");

    a_no_write_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!acc_ctl.wr_en || !acc_ctl.rd_en) && (!stat_ctl.wr_en || !stat_ctl.rd_en))
        else $error("RAM read and write in the same cycle");

endmodule

// ===== tb/feature_zscore_normalizer_core_test.sv =====
// Self-checking testbench for feature_zscore_normalizer_core; needs fzn_pkg and the core.
// Beats go through the start/busy handshake and every normalise result is
// checked against a predictor built into this file.
`timescale 1ns / 1ps

module feature_zscore_normalizer_core_test;
    import fzn_pkg::*;

    localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;
    localparam int         TARGET_BEATS     = 650;
    localparam longint     SUM_HI           = 64'sd549755813887;
    localparam longint     SUM_LO           = -64'sd549755813888;
    localparam logic [63:0] SQ_HI           = 64'h3FFF_FFFF_FFFF_FFFF;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_in_item    i_item;
    logic        i_cfg_we;
    logic [FC_W-1:0] i_cfg_wdata;
    logic        o_strobe;
    t_out_item   o_result;

    feature_zscore_normalizer_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

    // Predictor state.
    longint      acc_sum [MAX_FEATURES];
    logic [63:0] acc_sq  [MAX_FEATURES];
    logic [16:0] n_samples;
    logic signed [Q_W-1:0] mean_tab [MAX_FEATURES];
    logic signed [Q_W-1:0] prec_tab [MAX_FEATURES];
    logic        stats_ready;
    int          feat_limit;

    t_out_item   pending_norm[$];
    int          errors;
    int          beats_sent;
    int          results_seen;
    int          finalise_count;
    bit          no_gaps;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    task automatic report(input string what);
        errors++;
        $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    function automatic logic signed [Q_W-1:0] clamp_q(input longint v);
        if (v > longint'(Q_MAX)) return Q_MAX;
        if (v < longint'(Q_MIN)) return Q_MIN;
        return v[Q_W-1:0];
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = '0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Mean rounded to nearest, halves away from zero.
    function automatic logic signed [Q_W-1:0] mean_of(input longint s, input longint n);
        longint mag;
        longint q;
        if (n == 0) return '0;
        mag = (s < 0) ? -s : s;
        q   = (mag + n / 2) / n;
        if (q > 8388608) q = 8388608;
        return clamp_q((s < 0) ? -q : q);
    endfunction

    // 1/sqrt of the sample variance from the one-pass sums.
    function automatic logic signed [Q_W-1:0] precision_of(input longint s,
                                                           input logic [63:0] sq,
                                                           input longint n);
        logic [127:0] a;
        logic [127:0] b;
        logic [127:0] v;
        logic [127:0] t;
        logic [63:0]  mag;
        logic [63:0]  p;
        if (n < 2) return Q_MAX;
        mag = (s < 0) ? 64'(-s) : 64'(s);
        a   = 128'(sq) * 128'(n);
        b   = 128'(mag) * 128'(mag);
        if (a <= b) return Q_MAX;
        v = (a - b) / 128'(n * (n - 1));
        if (v >= (128'd1 << 64)) v = 128'hFFFF_FFFF_FFFF_FFFF;
        if (v <= 1) return Q_MAX;
        t = (128'd1 << 64) / v;
        p = int_sqrt(t[63:0]);
        return (p > 64'(Q_MAX)) ? Q_MAX : p[Q_W-1:0];
    endfunction

    task automatic predict(input t_in_item it);
        longint    val;
        longint    s;
        longint    m;
        longint    p;
        longint    prod;
        logic [63:0] sq;
        int        idx;
        t_out_item r;
        val = longint'(it.value);
        idx = it.feature_index;
        case (it.kind)
            KIND_ACC: begin
                s = acc_sum[idx] + val;
                acc_sum[idx] = (s > SUM_HI) ? SUM_HI : ((s < SUM_LO) ? SUM_LO : s);
                sq = acc_sq[idx] + 64'(val * val);
                acc_sq[idx] = (sq > SQ_HI) ? SQ_HI : sq;
                if (it.sample_end && n_samples < MAX_SAMPLES) n_samples++;
            end
            KIND_NORM: begin
                m    = longint'(mean_tab[idx]);
                p    = longint'(prec_tab[idx]);
                prod = (val - m) * p + 32768;
                r.out_feature = it.feature_index;
                r.normalized  = clamp_q(prod >>> 16);
                r.stats_ready = stats_ready;
                pending_norm = {pending_norm, r};
            end
            KIND_LD_MEAN: begin
                mean_tab[idx] = it.value;
                stats_ready   = 1'b1;
            end
            KIND_LD_PREC: begin
                prec_tab[idx] = it.value;
                stats_ready   = 1'b1;
            end
            KIND_FINAL: begin
                for (int f = 0; f < MAX_FEATURES; f++) begin
                    if (f < feat_limit) begin
                        mean_tab[f] = mean_of(acc_sum[f], n_samples);
                        prec_tab[f] = precision_of(acc_sum[f], acc_sq[f], n_samples);
                    end
                    acc_sum[f] = 0;
                    acc_sq[f]  = '0;
                end
                n_samples   = '0;
                stats_ready = 1'b1;
                finalise_count++;
            end
            default: ;
        endcase
    endtask

    // Sends one beat after an optional random gap and returns once it has been taken.
    task automatic send_beat(input logic [2:0] k, input int idx, input int val,
                             input bit last);
        t_in_item it;
        int gap;
        it.kind          = k;
        it.feature_index = idx[5:0];
        it.value         = val[Q_W-1:0];
        it.sample_end    = last;
        gap = 0;
        if (!no_gaps && $urandom_range(0, 9) >= 7)
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        predict(it);
        beats_sent++;
    endtask

    // Lets the block drain completely, with no normalise result outstanding.
    task automatic settle();
        start <= 1'b0;
        do @(posedge i_clk); while (busy || pending_norm.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_feature_count(input int fc);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= fc[FC_W-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        feat_limit  = (fc < MAX_FEATURES) ? fc : MAX_FEATURES;
    endtask

    function automatic int rand_q();
        return int'($urandom_range(0, 32'hFF_FFFF)) - 8388608;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_strobe) begin
            results_seen++;
            if (pending_norm.size() == 0) begin
                report("normalise result with nothing outstanding");
            end else begin
                want = pending_norm.pop_front();
                if (o_result.out_feature !== want.out_feature)
                    report($sformatf("out_feature %0d, expected %0d",
                                     o_result.out_feature, want.out_feature));
                if (o_result.normalized !== want.normalized)
                    report($sformatf("feature %0d normalized %0d, expected %0d",
                                     want.out_feature, o_result.normalized, want.normalized));
                if (o_result.stats_ready !== want.stats_ready)
                    report($sformatf("feature %0d stats_ready %0b, expected %0b",
                                     want.out_feature, o_result.stats_ready, want.stats_ready));
            end
        end
    end

    // Extremes, loads, spare kinds, normalising before any statistics exist,
    // finalising with no samples, one sample and constant data.
    task automatic test_directed();
        send_beat(KIND_NORM, 0, 8388607, 1'b0);
        send_beat(KIND_NORM, 63, -8388608, 1'b1);
        send_beat(KIND_LD_MEAN, 5, -8388608, 1'b0);
        send_beat(KIND_LD_PREC, 5, 8388607, 1'b1);
        send_beat(KIND_NORM, 5, 8388607, 1'b0);
        send_beat(KIND_LD_MEAN, 6, 8388607, 1'b0);
        send_beat(KIND_LD_PREC, 6, -8388608, 1'b0);
        send_beat(KIND_NORM, 6, -8388608, 1'b0);
        send_beat(KIND_NORM, 6, 8388607, 1'b0);
        send_beat(KIND_LD_PREC, 7, 65536, 1'b0);
        send_beat(KIND_NORM, 7, -1, 1'b0);
        for (int k = KIND_SPARE_FIRST; k <= KIND_SPARE_LAST; k++)
            send_beat(k[2:0], 7, 123456, 1'b1);
        send_beat(KIND_NORM, 7, 12345, 1'b0);
        send_beat(KIND_FINAL, 0, 0, 1'b0);
        send_beat(KIND_NORM, 3, 65536, 1'b0);
        send_beat(KIND_ACC, 1, 8388607, 1'b1);
        send_beat(KIND_FINAL, 0, 0, 1'b0);
        send_beat(KIND_NORM, 1, 8388607, 1'b0);
        for (int s = 0; s < 3; s++)
            send_beat(KIND_ACC, 2, -200000, 1'b1);
        send_beat(KIND_FINAL, 0, 0, 1'b0);
        send_beat(KIND_NORM, 2, -200000, 1'b0);
        send_beat(KIND_NORM, 2, 0, 1'b0);
        settle();
    endtask

    // Training rounds at a series of feature counts, each usually finalised and then
    // normalised, with stray loads and spare kinds mixed in.
    task automatic test_training_rounds();
        int fixed_fc[5];
        int round;
        int fc;
        int span;
        int nsamp;
        int mode;
        int idx;
        int val;
        int base[8];
        fixed_fc = '{1, 64, 0, 127, 2};
        round = 0;
        while (beats_sent < TARGET_BEATS) begin
            if (round < 5) fc = fixed_fc[round];
            else if ($urandom_range(0, 7) == 0) fc = $urandom_range(11, 127);
            else fc = $urandom_range(1, 10);
            set_feature_count(fc);
            no_gaps = ($urandom_range(0, 3) == 0);
            span  = (fc == 0) ? 4 : ((fc < 6) ? fc : 6);
            nsamp = $urandom_range(0, 6);
            mode  = $urandom_range(0, 5);
            for (int f = 0; f < 8; f++)
                base[f] = (mode == 0) ? rand_q() : int'($urandom_range(0, 400000)) - 200000;
            for (int s = 0; s < nsamp; s++) begin
                for (int f = 0; f < span; f++) begin
                    idx = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : f;
                    case (mode)
                        0, 1:    val = base[f];
                        2:       val = rand_q();
                        default: val = base[f] + int'($urandom_range(0, 80000)) - 40000;
                    endcase
                    send_beat(KIND_ACC, idx, val, f == span - 1);
                end
                if ($urandom_range(0, 5) == 0)
                    send_beat(3'(KIND_SPARE_FIRST + $urandom_range(0, 2)),
                              $urandom_range(0, 63), rand_q(), 1'($urandom_range(0, 1)));
            end
            if ($urandom_range(0, 5) == 0)
                send_beat($urandom_range(0, 1) ? KIND_LD_MEAN : KIND_LD_PREC,
                          $urandom_range(0, 63), rand_q(), 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 5) != 0)
                send_beat(KIND_FINAL, $urandom_range(0, 63), rand_q(),
                          1'($urandom_range(0, 1)));
            for (int j = 0; j < 14; j++) begin
                idx = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63)
                                                  : $urandom_range(0, span - 1);
                val = ($urandom_range(0, 1) == 0) ? rand_q()
                                                  : base[idx % 8] + int'($urandom_range(0, 80000)) - 40000;
                send_beat(KIND_NORM, idx, val, 1'($urandom_range(0, 1)));
            end
            round++;
        end
        settle();
    endtask

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        errors = 0;
        beats_sent = 0;
        results_seen = 0;
        finalise_count = 0;
        no_gaps = 1'b0;
        for (int f = 0; f < MAX_FEATURES; f++) begin
            acc_sum[f]  = 0;
            acc_sq[f]   = '0;
            mean_tab[f] = '0;
            prec_tab[f] = '0;
        end
        n_samples   = '0;
        stats_ready = 1'b0;
        feat_limit  = 64;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_training_rounds();
        repeat (10) @(posedge i_clk);

        $display("Covered %0d beats, %0d normalise results and %0d finalise passes,",
                 beats_sent, results_seen, finalise_count);
        $display("over feature counts from 0 to 127 with random gaps between beats.");
        if (errors == 0 && pending_norm.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #60_000_000;
        $display("Timed out with %0d results outstanding.", pending_norm.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
